>>> rtl/soa_pkg.sv
package soa_pkg;

  localparam int NUM_PAGES_DEF   = 64;
  localparam int CLASS_COUNT_DEF = 8;
  localparam int MAX_SLOTS       = 256;
  localparam int PAGE_BYTES      = 4096;
  localparam int HDR_BYTES       = 20;
  localparam int MIN_SHIFT       = 4;
  localparam int NEXT_W          = 11;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_PAGE   = 2'd2,
    ST_NOT_OWNED = 2'd3
  } soa_status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } soa_kind_t;

  typedef enum logic {
    CFG_POOL_BASE = 1'b0,
    CFG_PAGES_ALLOWED = 1'b1
  } soa_cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_PTWAIT,
    S_EXEC,
    S_LKWAIT,
    S_RESP
  } soa_state_t;

  // One page descriptor as kept in the page table memory
  typedef struct packed {
    logic [2:0]        cls;
    logic [7:0]        free_cnt;
    logic [7:0]        stack_top;
    logic [7:0]        fresh_left;
    logic [NEXT_W-1:0] next;
  } soa_page_t;

  // Objects per page for a class, capped at MAX_SLOTS - 1
  function automatic logic [7:0] slots_for(input logic [2:0] cls);
    int n;
    n = (PAGE_BYTES - HDR_BYTES) >> (MIN_SHIFT + int'(cls));
    if (n > MAX_SLOTS - 1) n = MAX_SLOTS - 1;
    return 8'(n);
  endfunction

endpackage

>>> rtl/soa_if.sv
interface soa_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] request_size;
  logic [31:0] free_address;
  modport source (output valid, kind, request_size, free_address, input ready);
  modport sink   (input valid, kind, request_size, free_address, output ready);
endinterface

interface soa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] object_address;
  logic [1:0]  status;
  modport source (output valid, object_address, status, input ready);
  modport sink   (input valid, object_address, status, output ready);
endinterface

interface soa_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/slab_object_allocator_top.sv
// Slab allocator for power-of-two object classes (16 bytes up) on a pool of
// NUM_PAGES pages of 4 KiB. An allocate request takes a slot from the newest
// partial page of its class (last freed slot first, else the highest fresh
// slot); a free request returns a slot. A free of address 0 gets status 0
// and changes nothing; any other free is rejected with status 3 unless it
// names an object start in a taken page. Each item gets exactly one result.
// One item is in work at a time. A request that reads a page descriptor (an
// allocate from fresh slots of a partial page, or a free that reaches its
// page) waits on the registered read of the page table memory; to pop a freed
// slot, the link memory is read after it. A new-page allocate and requests
// answered at decode read neither memory. The next item can be accepted in
// the cycle after the result is loaded. A finished result waits in the output
// register while the next item is accepted. Reset needs no clearing pass.
module slab_object_allocator_top
  import soa_pkg::*;
#(
  parameter int NUM_PAGES   = NUM_PAGES_DEF,
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  soa_in_if.sink          in_ch,
  soa_out_if.source       out_ch,
  soa_cfg_if.sink         cfg_ch
);

  localparam int PI_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int PH_W  = $clog2(NUM_PAGES + 1);
  localparam int CL_W  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int LK_W  = PI_W + 8;
  localparam logic [PH_W-1:0] NONE_PAGE = PH_W'(NUM_PAGES);
  localparam logic [32:0] MAX_SIZE = 33'(16) << (CLASS_COUNT - 1);

  soa_state_t state_r, state_nxt;

  logic [19:0]      base_r;
  logic [6:0]       allowed_r;
  logic [PH_W-1:0]  taken_r, taken_nxt;
  logic [PH_W-1:0]  head_r [CLASS_COUNT];
  logic             head_we;
  logic [CL_W-1:0]  head_widx;
  logic [PH_W-1:0]  head_wdata;

  logic             kind_r;
  logic [31:0]      size_r;
  logic [31:0]      addr_r;
  logic [2:0]       cls_r, cls_nxt;
  logic [PI_W-1:0]  pidx_r, pidx_nxt;
  soa_page_t        ent_r, ent_nxt;
  logic [31:0]      res_addr_r, res_addr_nxt;
  soa_status_t      res_stat_r, res_stat_nxt;

  logic             out_valid_r;
  logic [31:0]      out_addr_r;
  soa_status_t      out_stat_r;

  soa_page_t        pt_mem [NUM_PAGES];
  soa_page_t        pt_rdata_r;
  logic             pt_re, pt_we;
  logic [PI_W-1:0]  pt_raddr;
  soa_page_t        pt_wdata;

  logic [7:0]       lk_mem [NUM_PAGES * MAX_SLOTS];
  logic [7:0]       lk_rdata_r;
  logic             lk_re, lk_we;
  logic [LK_W-1:0]  lk_raddr, lk_waddr;
  logic [7:0]       lk_wdata;

  logic             in_acc;
  logic             resp_load;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.object_address = out_addr_r;
  assign out_ch.status = out_stat_r;
  assign resp_load     = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pidx_r] <= pt_wdata;
    if (pt_re) pt_rdata_r <= pt_mem[pt_raddr];
    if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
    if (lk_re) lk_rdata_r <= lk_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      allowed_r   <= 7'd64;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) head_r[i] <= NONE_PAGE;
    end else begin
      state_r <= state_nxt;
      taken_r <= taken_nxt;
      if (head_we) head_r[head_widx] <= head_wdata;
      if (cfg_ch.valid) begin
        unique case (soa_cfg_idx_t'(cfg_ch.index))
          CFG_POOL_BASE:     base_r <= cfg_ch.data;
          CFG_PAGES_ALLOWED: allowed_r <= cfg_ch.data[6:0];
        endcase
      end
      if (resp_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_ch.kind;
      size_r <= in_ch.request_size;
      addr_r <= in_ch.free_address;
    end
    cls_r      <= cls_nxt;
    pidx_r     <= pidx_nxt;
    ent_r      <= ent_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    if (resp_load) begin
      out_addr_r <= res_addr_r;
      out_stat_r <= res_stat_r;
    end
  end

  logic [2:0]      a_cls;
  logic [PH_W-1:0] a_head;
  logic [19:0]     f_page;
  logic [11:0]     f_rel;
  logic [11:0]     f_mask;
  logic [11:0]     f_slot;
  logic [7:0]      f_total;
  logic [7:0]      a_slot;
  logic [19:0]     obj_page;
  logic            pool_full;

  always_comb begin
    a_cls = 3'(CLASS_COUNT - 1);
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (33'(size_r) <= (33'(16) << c)) a_cls = 3'(c);
    end
    a_head    = head_r[a_cls[CL_W-1:0]];
    f_page    = addr_r[31:12] - base_r;
    f_rel     = addr_r[11:0] - 12'(HDR_BYTES);
    f_mask    = (12'd1 << (MIN_SHIFT + int'(ent_r.cls))) - 12'd1;
    f_slot    = f_rel >> (MIN_SHIFT + int'(ent_r.cls));
    f_total   = slots_for(ent_r.cls);
    pool_full = (11'(taken_r) >= 11'(allowed_r)) || (11'(taken_r) >= 11'(NUM_PAGES));
    obj_page  = base_r + 20'(pidx_r);
    a_slot    = (state_r == S_LKWAIT) ? ent_r.stack_top : ent_r.fresh_left - 8'd1;

    state_nxt    = state_r;
    taken_nxt    = taken_r;
    cls_nxt      = cls_r;
    pidx_nxt     = pidx_r;
    ent_nxt      = ent_r;
    res_addr_nxt = res_addr_r;
    res_stat_nxt = res_stat_r;
    head_we      = 1'b0;
    head_widx    = cls_r[CL_W-1:0];
    head_wdata   = a_head;
    pt_re        = 1'b0;
    pt_raddr     = pidx_r;
    pt_we        = 1'b0;
    pt_wdata     = ent_r;
    lk_re        = 1'b0;
    lk_raddr     = {pidx_r, ent_r.stack_top};
    lk_we        = 1'b0;
    lk_waddr     = {pidx_r, f_slot[7:0]};
    lk_wdata     = ent_r.stack_top;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_DEC;
      end
      S_DEC: begin
        res_addr_nxt = '0;
        res_stat_nxt = ST_OK;
        if (soa_kind_t'(kind_r) == KIND_ALLOC) begin
          cls_nxt = a_cls;
          if (size_r == '0 || 33'(size_r) > MAX_SIZE) begin
            res_stat_nxt = ST_BAD_SIZE;
            state_nxt    = S_RESP;
          end else if (a_head == NONE_PAGE) begin
            if (pool_full) begin
              res_stat_nxt = ST_NO_PAGE;
              state_nxt    = S_RESP;
            end else begin
              // take the next pool page and push it on the class list
              pidx_nxt           = taken_r[PI_W-1:0];
              taken_nxt          = taken_r + PH_W'(1);
              ent_nxt.cls        = a_cls;
              ent_nxt.free_cnt   = slots_for(a_cls);
              ent_nxt.fresh_left = slots_for(a_cls);
              ent_nxt.stack_top  = '0;
              ent_nxt.next       = NEXT_W'(NONE_PAGE);
              head_we            = 1'b1;
              head_widx          = a_cls[CL_W-1:0];
              head_wdata         = taken_r;
              state_nxt          = S_EXEC;
            end
          end else begin
            pidx_nxt  = a_head[PI_W-1:0];
            pt_re     = 1'b1;
            pt_raddr  = a_head[PI_W-1:0];
            state_nxt = S_PTWAIT;
          end
        end else begin
          if (addr_r == '0) begin
            state_nxt = S_RESP;
          end else if (f_page >= 20'(taken_r)) begin
            res_stat_nxt = ST_NOT_OWNED;
            state_nxt    = S_RESP;
          end else begin
            pidx_nxt  = f_page[PI_W-1:0];
            pt_re     = 1'b1;
            pt_raddr  = f_page[PI_W-1:0];
            state_nxt = S_PTWAIT;
          end
        end
      end
      S_PTWAIT: begin
        ent_nxt   = pt_rdata_r;
        state_nxt = S_EXEC;
      end
      S_EXEC, S_LKWAIT: begin
        if (soa_kind_t'(kind_r) == KIND_ALLOC) begin
          if (state_r == S_EXEC && ent_r.free_cnt != ent_r.fresh_left) begin
            // pop the freed-slot stack: fetch the link below the top
            lk_re     = 1'b1;
            state_nxt = S_LKWAIT;
          end else begin
            pt_we = 1'b1;
            if (state_r == S_LKWAIT) pt_wdata.stack_top = lk_rdata_r;
            else pt_wdata.fresh_left = ent_r.fresh_left - 8'd1;
            pt_wdata.free_cnt = ent_r.free_cnt - 8'd1;
            if (ent_r.free_cnt == 8'd1) begin
              // page now full: drop it from the class list
              pt_wdata.next = NEXT_W'(NONE_PAGE);
              head_we       = 1'b1;
              head_widx     = cls_r[CL_W-1:0];
              head_wdata    = PH_W'(ent_r.next);
            end
            res_addr_nxt = {obj_page, 12'd0} + 32'(HDR_BYTES)
                           + (32'(a_slot) << (MIN_SHIFT + int'(cls_r)));
            res_stat_nxt = ST_OK;
            state_nxt    = S_RESP;
          end
        end else begin
          state_nxt = S_RESP;
          if (addr_r[11:0] < 12'(HDR_BYTES) || (f_rel & f_mask) != '0
              || f_slot >= 12'(f_total)) begin
            res_stat_nxt = ST_NOT_OWNED;
          end else if (ent_r.free_cnt < f_total) begin
            lk_we              = 1'b1;
            pt_we              = 1'b1;
            pt_wdata.stack_top = f_slot[7:0];
            pt_wdata.free_cnt  = ent_r.free_cnt + 8'd1;
            if (ent_r.free_cnt == '0) begin
              // page regains a slot: push it back on the class list
              pt_wdata.next = NEXT_W'(head_r[ent_r.cls[CL_W-1:0]]);
              head_we       = 1'b1;
              head_widx     = ent_r.cls[CL_W-1:0];
              head_wdata    = PH_W'(pidx_r);
            end
          end
        end
      end
      S_RESP: begin
        if (resp_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    11'(taken_r) <= 11'(NUM_PAGES))
    else $error("pages taken beyond pool size");

  a_taken_step: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r != $past(taken_r) |-> taken_r == $past(taken_r) + PH_W'(1)
      && $past(state_r) == S_DEC)
    else $error("pool page taken outside decode");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_DEC)
    else $error("accepted item not decoded");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP && out_valid_r && !out_ch.ready |=> state_r == S_RESP)
    else $error("result overwrote a waiting result");

endmodule
